// ===== hdl/grid_union_find_wall_opener_unit_macros.svh =====
// assertion macros for the grid union-find wall opener checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GRID_UNION_FIND_WALL_OPENER_UNIT_MACROS_SVH
`define GRID_UNION_FIND_WALL_OPENER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define GUFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define GUFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define GUFW_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gufw_pkg.sv =====
// shared types and constants for the grid union-find wall opener
// no dependencies
`default_nettype none

package gufw_pkg;

    localparam int CELL_W        = 12;
    localparam int DIM_W         = 7;
    localparam int AREA_W        = 2 * DIM_W;
    localparam int SIZE_W        = CELL_W + 1;
    localparam int GRID_CELLS    = 4096;
    localparam int MAX_CELLS_DEF = 4096;
    localparam int DIM_MAX       = 64;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [1:0] OP_UNITE = 2'd0;
    localparam logic [1:0] OP_FORCE = 2'd1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_OFF_GRID     = 3'd1;
    localparam logic [2:0] ST_SAME_SET     = 3'd2;
    localparam logic [2:0] ST_ALREADY_OPEN = 3'd3;
    localparam logic [2:0] ST_BAD_CELL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_HEIGHT = 1'b1;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_MOD      = 14'b00000000000100,
        S_FIND_RD  = 14'b00000000001000,
        S_WALK     = 14'b00000000010000,
        S_COMP_RD  = 14'b00000000100000,
        S_COMP     = 14'b00000001000000,
        S_FIND_END = 14'b00000010000000,
        S_LINK     = 14'b00000100000000,
        S_FORCE_RD = 14'b00001000000000,
        S_FORCE    = 14'b00010000000000,
        S_OPEN     = 14'b00100000000000,
        S_WALL_RD  = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

// ===== hdl/gufw_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module gufw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/gufw_mod.sv =====
// iterative remainder unit, one shift-compare-subtract step per cycle
// depends on gufw_pkg
`default_nettype none

module gufw_mod (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [gufw_pkg::CELL_W-1:0] i_dividend,
    input  wire logic [gufw_pkg::DIM_W-1:0]  i_divisor,
    output gufw_pkg::t_mod_rsp               o_rsp
);

    localparam int CNT_W = $clog2(gufw_pkg::CELL_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [gufw_pkg::CELL_W-1:0] r_quo;
    logic [gufw_pkg::DIM_W-1:0]  r_rem;

    logic [gufw_pkg::DIM_W-1:0]  w_trial;
    logic                        w_ge;
    logic [gufw_pkg::DIM_W-1:0]  w_rem_nx;

    always_comb begin
        w_trial  = {r_rem[gufw_pkg::DIM_W-2:0], r_quo[gufw_pkg::CELL_W-1]};
        w_ge     = (w_trial >= i_divisor);
        w_rem_nx = w_ge ? (w_trial - i_divisor) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(gufw_pkg::CELL_W - 1);
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_quo <= {r_quo[gufw_pkg::CELL_W-2:0], 1'b0};
            r_rem <= w_rem_nx;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/grid_union_find_wall_opener_unit.sv =====
// Grid maze wall opener on a disjoint-set forest.
// Input channel s_axis: one transaction per request (unite, force open, read).
// Output channel m_axis: exactly one result transaction per request, in order.
// Config channel i_cfg_*: writes grid width (index 0) or height (index 1),
// clamped to 1..64; always ready, to be used only while the block is idle.
// From acceptance to the output register: a bad cell goes there directly, a
// read first reads the wall rams; a connect first runs the 12-step remainder
// unit that finds the column; then off grid reads the walls, a forced connect
// reads its wall, opens it unless already open and reads the walls, and a
// uniting connect walks and compresses each of the two chains to its root,
// links the first root under the second and opens the wall, unless both
// cells share a set. The next request is taken the cycle after the result is
// loaded. The parent, root and wall rams have one read and one write port. One
// request is in flight at a time. After reset a clearing pass marks each of the
// min(MAX_CELLS, 4096) cells a root with closed walls, with s_axis_tready low.
// A finished result sits in the output register; while the receiver stalls
// the next request is still accepted and processed, and the block holds in
// its last step until the output register is free.
// depends on gufw_pkg, gufw_ram, gufw_mod
`default_nettype none

module grid_union_find_wall_opener_unit #(
    parameter int MAX_CELLS = gufw_pkg::MAX_CELLS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [13:2] cell_req, [15:14] direction
    input  wire logic [gufw_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] opened, [3:1] status, [4] right_open, [5] down_open, [7:6] zero
    output logic      [gufw_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gufw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gufw_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = (MAX_CELLS < gufw_pkg::GRID_CELLS) ? MAX_CELLS
                                                               : gufw_pkg::GRID_CELLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIZE_W = gufw_pkg::SIZE_W;
    localparam int DIM_W  = gufw_pkg::DIM_W;
    localparam int CELL_W = gufw_pkg::CELL_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] v;
        begin
            v = d;
            if (d == '0) begin
                v = DIM_W'(1);
            end else if (d > DIM_W'(gufw_pkg::DIM_MAX)) begin
                v = DIM_W'(gufw_pkg::DIM_MAX);
            end
            return v;
        end
    endfunction

    // control registers
    gufw_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_out_valid, n_out_valid;
    logic [DIM_W-1:0] r_w, r_h;

    // payload registers
    logic [1:0]                 r_op, n_op;
    logic [CELL_W-1:0]          r_cell, n_cell;
    logic [1:0]                 r_dir, n_dir;
    logic                       r_bad, n_bad;
    logic                       r_opened, n_opened;
    logic [2:0]                 r_status, n_status;
    logic [AW-1:0]              r_nb, n_nb;
    logic [AW-1:0]              r_wall_cell, n_wall_cell;
    logic                       r_wall_down, n_wall_down;
    logic [AW-1:0]              r_r, n_r;
    logic [AW-1:0]              r_x, n_x;
    logic [AW-1:0]              r_c, n_c;
    logic [AW-1:0]              r_a, n_a;
    logic                       r_second, n_second;
    logic [gufw_pkg::OUT_W-1:0] r_out_data, n_out_data;

    // ram ports
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we_root, w_we_parent, w_we_right, w_we_down;
    logic          w_root_wdata, w_wall_wdata;
    logic          w_root_q, w_right_q, w_down_q;
    logic [AW-1:0] w_parent_q;

    // geometry
    logic [gufw_pkg::AREA_W-1:0] w_area;
    logic [SIZE_W-1:0]           w_size;
    logic [1:0]                  w_in_op;
    logic [CELL_W-1:0]           w_in_cell;
    logic [1:0]                  w_in_dir;
    logic [SIZE_W-1:0]           w_cell_x, w_w_x, w_nb_x;
    logic                        w_off;
    logic [AW-1:0]               w_wall_cell;
    logic                        w_wall_down;
    logic                        w_mod_start;
    gufw_pkg::t_mod_rsp          w_mod;

    assign w_in_op   = s_axis_tdata[1:0];
    assign w_in_cell = s_axis_tdata[13:2];
    assign w_in_dir  = s_axis_tdata[15:14];

    assign w_area = gufw_pkg::AREA_W'(r_w) * gufw_pkg::AREA_W'(r_h);
    assign w_size = (w_area > gufw_pkg::AREA_W'(DEPTH)) ? SIZE_W'(DEPTH) : SIZE_W'(w_area);

    assign s_axis_tready = (r_state == gufw_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    gufw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_in_cell),
        .i_divisor  (r_w),
        .o_rsp      (w_mod)
    );

    gufw_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_root),
        .i_waddr (w_waddr),
        .i_wdata (w_root_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_root_q)
    );

    gufw_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_parent),
        .i_waddr (w_waddr),
        .i_wdata (r_r),
        .i_raddr (w_raddr),
        .o_rdata (w_parent_q)
    );

    gufw_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_right),
        .i_waddr (w_waddr),
        .i_wdata (w_wall_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_right_q)
    );

    gufw_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_down_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_down),
        .i_waddr (w_waddr),
        .i_wdata (w_wall_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_down_q)
    );

    // neighbor and wall location once the column is known
    always_comb begin
        w_cell_x    = SIZE_W'(r_cell);
        w_w_x       = SIZE_W'(r_w);
        w_off       = 1'b0;
        w_nb_x      = w_cell_x;
        w_wall_cell = r_cell[AW-1:0];
        w_wall_down = 1'b0;
        case (r_dir)
            gufw_pkg::DIR_UP: begin
                w_off       = (w_cell_x < w_w_x);
                w_nb_x      = w_cell_x - w_w_x;
                w_wall_cell = w_nb_x[AW-1:0];
                w_wall_down = 1'b1;
            end
            gufw_pkg::DIR_DOWN: begin
                w_nb_x      = w_cell_x + w_w_x;
                w_off       = (w_nb_x >= w_size);
                w_wall_down = 1'b1;
            end
            gufw_pkg::DIR_LEFT: begin
                w_off       = (w_mod.rem == '0);
                w_nb_x      = w_cell_x - SIZE_W'(1);
                w_wall_cell = w_nb_x[AW-1:0];
            end
            default: begin
                w_nb_x = w_cell_x + SIZE_W'(1);
                w_off  = (w_mod.rem == (r_w - DIM_W'(1))) || (w_nb_x >= w_size);
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_op        = r_op;
        n_cell      = r_cell;
        n_dir       = r_dir;
        n_bad       = r_bad;
        n_opened    = r_opened;
        n_status    = r_status;
        n_nb        = r_nb;
        n_wall_cell = r_wall_cell;
        n_wall_down = r_wall_down;
        n_r         = r_r;
        n_x         = r_x;
        n_c         = r_c;
        n_a         = r_a;
        n_second    = r_second;
        n_out_data  = r_out_data;

        w_raddr      = r_cell[AW-1:0];
        w_waddr      = r_c;
        w_we_root    = 1'b0;
        w_we_parent  = 1'b0;
        w_we_right   = 1'b0;
        w_we_down    = 1'b0;
        w_root_wdata = 1'b0;
        w_wall_wdata = 1'b1;
        w_mod_start  = 1'b0;

        unique case (r_state)
            gufw_pkg::S_CLEAR: begin
                w_waddr      = r_clr;
                w_we_root    = 1'b1;
                w_we_right   = 1'b1;
                w_we_down    = 1'b1;
                w_root_wdata = 1'b1;
                w_wall_wdata = 1'b0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = gufw_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            gufw_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op     = w_in_op;
                    n_cell   = w_in_cell;
                    n_dir    = w_in_dir;
                    n_bad    = 1'b0;
                    n_opened = 1'b0;
                    n_status = gufw_pkg::ST_OK;
                    if (SIZE_W'(w_in_cell) >= w_size) begin
                        n_bad    = 1'b1;
                        n_status = gufw_pkg::ST_BAD_CELL;
                        n_state  = gufw_pkg::S_OUT;
                    end else if ((w_in_op == gufw_pkg::OP_UNITE) ||
                                 (w_in_op == gufw_pkg::OP_FORCE)) begin
                        w_mod_start = 1'b1;
                        n_state     = gufw_pkg::S_MOD;
                    end else begin
                        n_state = gufw_pkg::S_WALL_RD;
                    end
                end
            end
            gufw_pkg::S_MOD: begin
                if (w_mod.done) begin
                    n_nb        = w_nb_x[AW-1:0];
                    n_wall_cell = w_wall_cell;
                    n_wall_down = w_wall_down;
                    if (w_off) begin
                        n_status = gufw_pkg::ST_OFF_GRID;
                        n_state  = gufw_pkg::S_WALL_RD;
                    end else if (r_op == gufw_pkg::OP_UNITE) begin
                        n_r      = r_cell[AW-1:0];
                        n_x      = r_cell[AW-1:0];
                        n_second = 1'b0;
                        n_state  = gufw_pkg::S_FIND_RD;
                    end else begin
                        n_state = gufw_pkg::S_FORCE_RD;
                    end
                end
            end
            gufw_pkg::S_FIND_RD: begin
                w_raddr = r_r;
                n_state = gufw_pkg::S_WALK;
            end
            gufw_pkg::S_WALK: begin
                if (w_root_q) begin
                    n_c     = r_x;
                    n_state = gufw_pkg::S_COMP_RD;
                end else begin
                    n_r     = w_parent_q;
                    w_raddr = w_parent_q;
                end
            end
            gufw_pkg::S_COMP_RD: begin
                if (r_c == r_r) begin
                    n_state = gufw_pkg::S_FIND_END;
                end else begin
                    w_raddr = r_c;
                    n_state = gufw_pkg::S_COMP;
                end
            end
            gufw_pkg::S_COMP: begin
                // point this node at the root, step to its old parent
                w_waddr     = r_c;
                w_we_parent = 1'b1;
                n_c         = w_parent_q;
                if (w_parent_q == r_r) begin
                    n_state = gufw_pkg::S_FIND_END;
                end else begin
                    w_raddr = w_parent_q;
                end
            end
            gufw_pkg::S_FIND_END: begin
                if (!r_second) begin
                    n_a      = r_r;
                    n_second = 1'b1;
                    n_r      = r_nb;
                    n_x      = r_nb;
                    n_state  = gufw_pkg::S_FIND_RD;
                end else if (r_a == r_r) begin
                    n_status = gufw_pkg::ST_SAME_SET;
                    n_state  = gufw_pkg::S_WALL_RD;
                end else begin
                    n_state = gufw_pkg::S_LINK;
                end
            end
            gufw_pkg::S_LINK: begin
                // first root goes under the second
                w_waddr     = r_a;
                w_we_root   = 1'b1;
                w_we_parent = 1'b1;
                n_state     = gufw_pkg::S_OPEN;
            end
            gufw_pkg::S_FORCE_RD: begin
                w_raddr = r_wall_cell;
                n_state = gufw_pkg::S_FORCE;
            end
            gufw_pkg::S_FORCE: begin
                if (r_wall_down ? w_down_q : w_right_q) begin
                    n_status = gufw_pkg::ST_ALREADY_OPEN;
                    n_state  = gufw_pkg::S_WALL_RD;
                end else begin
                    n_state = gufw_pkg::S_OPEN;
                end
            end
            gufw_pkg::S_OPEN: begin
                w_waddr    = r_wall_cell;
                w_we_down  = r_wall_down;
                w_we_right = !r_wall_down;
                n_opened   = 1'b1;
                n_state    = gufw_pkg::S_WALL_RD;
            end
            gufw_pkg::S_WALL_RD: begin
                n_state = gufw_pkg::S_OUT;
            end
            gufw_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00,
                                   w_down_q && !r_bad,
                                   w_right_q && !r_bad,
                                   r_status,
                                   r_opened};
                    n_state     = gufw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gufw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gufw_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_w         <= DIM_W'(gufw_pkg::DIM_MAX);
            r_h         <= DIM_W'(gufw_pkg::DIM_MAX);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gufw_pkg::CFG_REG_WIDTH:  r_w <= clamp_dim(i_cfg_data);
                    gufw_pkg::CFG_REG_HEIGHT: r_h <= clamp_dim(i_cfg_data);
                    default: begin
                        r_w <= r_w;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_cell      <= n_cell;
        r_dir       <= n_dir;
        r_bad       <= n_bad;
        r_opened    <= n_opened;
        r_status    <= n_status;
        r_nb        <= n_nb;
        r_wall_cell <= n_wall_cell;
        r_wall_down <= n_wall_down;
        r_r         <= n_r;
        r_x         <= n_x;
        r_c         <= n_c;
        r_a         <= n_a;
        r_second    <= n_second;
        r_out_data  <= n_out_data;
    end

endmodule

`default_nettype wire

// ===== hdl/gufw_chk.sv =====
// port-level checker for the grid union-find wall opener, bound to the top level
// depends on gufw_pkg and grid_union_find_wall_opener_unit_macros.svh
`default_nettype none

`include "grid_union_find_wall_opener_unit_macros.svh"

module gufw_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [gufw_pkg::IN_W-1:0]      s_axis_tdata,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [gufw_pkg::OUT_W-1:0]     m_axis_tdata,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [gufw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [gufw_pkg::DIM_W-1:0]     i_cfg_data
);

    logic w_unused;
    assign w_unused = ^{s_axis_tdata, i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data};

    // a stalled result holds
    `GUFW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // bad cell reports closed walls and no opening
    `GUFW_ASSERT_NOW(a_bad_cell_clean, m_axis_tvalid && (m_axis_tdata[3:1] == gufw_pkg::ST_BAD_CELL), m_axis_tdata[5:4] == 2'b00 && !m_axis_tdata[0], "bad cell result not clean")

    // an opening always carries status ok
    `GUFW_ASSERT_NOW(a_opened_ok, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[3:1] == gufw_pkg::ST_OK, "opened with nonzero status")

    // one request in flight at a time
    `GUFW_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted two requests back to back")

    // clearing pass follows reset
    `GUFW_ASSERT_ALWAYS_NEXT(a_reset_clear, !i_rst_n, !s_axis_tready && !m_axis_tvalid, "ready or valid right after reset")

endmodule

bind grid_union_find_wall_opener_unit gufw_chk u_gufw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);

`default_nettype wire

// ===== tb/grid_union_find_wall_opener_unit_checker.sv =====
// result checker for the grid union-find wall opener: watches the config, request
// and result channels, keeps its own union-find forest and wall bits, and compares
// every result against its prediction; depends on gufw_pkg
module grid_union_find_wall_opener_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [gufw_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [gufw_pkg::OUT_W-1:0]     i_m_axis_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [gufw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gufw_pkg::DIM_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked
);

    // highest bit first, laid out as on m_axis_tdata[5:0]
    typedef struct packed {
        logic       down_open;
        logic       right_open;
        logic [2:0] status;
        logic       opened;
    } t_wall_result;

    int                          grid_w;
    int                          grid_h;
    bit                          root_flag  [gufw_pkg::GRID_CELLS];
    logic [gufw_pkg::CELL_W-1:0] parent_of  [gufw_pkg::GRID_CELLS];
    bit                          wall_right [gufw_pkg::GRID_CELLS];
    bit                          wall_down  [gufw_pkg::GRID_CELLS];
    t_wall_result                expected_q [$];
    t_wall_result                want;
    t_wall_result                got;
    int                          dim;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch on result %0d: %s is %0d, expected %0d",
                 o_checked, what, got_v, want_v);
        o_mismatches++;
    endtask

    // root lookup with full path compression
    function automatic int find_set_root(input int x);
        int r;
        int c;
        int nx;
        r = x;
        for (int n = 0; n < gufw_pkg::GRID_CELLS && !root_flag[r]; n++)
            r = int'(parent_of[r]);
        c = x;
        for (int n = 0; n < gufw_pkg::GRID_CELLS && c != r && !root_flag[c]; n++) begin
            nx = int'(parent_of[c]);
            parent_of[c] = r[gufw_pkg::CELL_W-1:0];
            c = nx;
        end
        return r;
    endfunction

    function automatic t_wall_result apply_request(input logic [1:0] op,
                                                   input logic [gufw_pkg::CELL_W-1:0] cell_idx,
                                                   input logic [1:0] dir);
        t_wall_result res;
        int  cells;
        int  c;
        int  nb;
        int  wall_cell;
        int  ra;
        int  rb;
        bit  off;
        bit  on_right;
        res = '0;
        cells = grid_w * grid_h;
        if (cells > gufw_pkg::GRID_CELLS)
            cells = gufw_pkg::GRID_CELLS;
        c = int'(cell_idx);
        if (c >= cells) begin
            res.status = gufw_pkg::ST_BAD_CELL;
            return res;
        end
        res.status = gufw_pkg::ST_OK;
        if (op == gufw_pkg::OP_UNITE || op == gufw_pkg::OP_FORCE) begin
            on_right = 1'b0;
            case (dir)
                gufw_pkg::DIR_UP: begin
                    off = c < grid_w;
                    nb = c - grid_w;
                    wall_cell = nb;
                end
                gufw_pkg::DIR_DOWN: begin
                    off = c + grid_w >= cells;
                    nb = c + grid_w;
                    wall_cell = c;
                end
                gufw_pkg::DIR_LEFT: begin
                    off = (c % grid_w) == 0;
                    nb = c - 1;
                    wall_cell = nb;
                    on_right = 1'b1;
                end
                default: begin
                    off = ((c + 1) % grid_w) == 0 || c + 1 >= cells;
                    nb = c + 1;
                    wall_cell = c;
                    on_right = 1'b1;
                end
            endcase
            if (off) begin
                res.status = gufw_pkg::ST_OFF_GRID;
            end else if (op == gufw_pkg::OP_UNITE) begin
                ra = find_set_root(c);
                rb = find_set_root(nb);
                if (ra == rb) begin
                    res.status = gufw_pkg::ST_SAME_SET;
                end else begin
                    parent_of[ra] = rb[gufw_pkg::CELL_W-1:0];
                    root_flag[ra] = 1'b0;
                    if (on_right)
                        wall_right[wall_cell] = 1'b1;
                    else
                        wall_down[wall_cell] = 1'b1;
                    res.opened = 1'b1;
                end
            end else if (on_right ? wall_right[wall_cell] : wall_down[wall_cell]) begin
                res.status = gufw_pkg::ST_ALREADY_OPEN;
            end else begin
                if (on_right)
                    wall_right[wall_cell] = 1'b1;
                else
                    wall_down[wall_cell] = 1'b1;
                res.opened = 1'b1;
            end
        end
        res.right_open = wall_right[c];
        res.down_open = wall_down[c];
        return res;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_w = gufw_pkg::DIM_MAX;
            grid_h = gufw_pkg::DIM_MAX;
            for (int i = 0; i < gufw_pkg::GRID_CELLS; i++) begin
                root_flag[i] = 1'b1;
                wall_right[i] = 1'b0;
                wall_down[i] = 1'b0;
            end
            expected_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                dim = (i_cfg_data == '0) ? 1 :
                      ((i_cfg_data > gufw_pkg::DIM_MAX) ? gufw_pkg::DIM_MAX
                                                         : int'(i_cfg_data));
                if (i_cfg_index == gufw_pkg::CFG_REG_WIDTH)
                    grid_w = dim;
                else
                    grid_h = dim;
            end
            // result side before request side: a result never belongs to a
            // request accepted at the same edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing pending, data", i_m_axis_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    got = t_wall_result'(i_m_axis_tdata[5:0]);
                    if (got.opened !== want.opened)
                        report_mismatch("opened", got.opened, want.opened);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.right_open !== want.right_open)
                        report_mismatch("right_open", got.right_open, want.right_open);
                    if (got.down_open !== want.down_open)
                        report_mismatch("down_open", got.down_open, want.down_open);
                    if (i_m_axis_tdata[gufw_pkg::OUT_W-1:6] !== '0)
                        report_mismatch("padding", i_m_axis_tdata[gufw_pkg::OUT_W-1:6], 0);
                end
                o_checked++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(apply_request(i_s_axis_tdata[1:0],
                                                   i_s_axis_tdata[13:2],
                                                   i_s_axis_tdata[15:14]));
            o_pending = expected_q.size();
        end
    end

endmodule

// ===== tb/grid_union_find_wall_opener_unit_test.sv =====
// top of the grid union-find wall opener testbench: clock, reset, grid settings,
// directed and random requests with idle gaps and receiver stalls, and the verdict;
// depends on gufw_pkg, the block and grid_union_find_wall_opener_unit_checker
module grid_union_find_wall_opener_unit_test;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;

    // read, and the spare code that also reads
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_READ_ALT = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [gufw_pkg::IN_W-1:0]      s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [gufw_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [gufw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [gufw_pkg::DIM_W-1:0]     i_cfg_data;

    int mismatches;
    int pending;
    int checked;
    int sent;
    int settings;
    int grid_cells;
    bit rx_hold_req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grid_union_find_wall_opener_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    grid_union_find_wall_opener_unit_checker wall_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_request(input logic [1:0] op, input int cell_idx,
                                input logic [1:0] dir);
        int gap;
        logic [gufw_pkg::CELL_W-1:0] cell_bits;
        gap = pick_gap();
        cell_bits = cell_idx[gufw_pkg::CELL_W-1:0];
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dir, cell_bits, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(input logic [gufw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gufw_pkg::DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [gufw_pkg::DIM_W-1:0] w_raw,
                            input logic [gufw_pkg::DIM_W-1:0] h_raw);
        int w;
        int h;
        quiesce();
        write_reg(gufw_pkg::CFG_REG_WIDTH, w_raw);
        write_reg(gufw_pkg::CFG_REG_HEIGHT, h_raw);
        w = (w_raw == 0) ? 1 : ((w_raw > gufw_pkg::DIM_MAX) ? gufw_pkg::DIM_MAX : int'(w_raw));
        h = (h_raw == 0) ? 1 : ((h_raw > gufw_pkg::DIM_MAX) ? gufw_pkg::DIM_MAX : int'(h_raw));
        grid_cells = w * h;
        settings++;
    endtask

    // mostly in-grid cells so the forest grows; a few raw indexes
    task automatic random_requests(input int count, input bit hold_rx, input bit pause_mid);
        int r;
        int cell_idx;
        logic [1:0] op;
        if (hold_rx)
            rx_hold_req = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2)
                quiesce();
            r = $urandom_range(0, 99);
            op = (r < 45) ? gufw_pkg::OP_UNITE :
                 (r < 70) ? gufw_pkg::OP_FORCE :
                 (r < 92) ? OP_READ : OP_READ_ALT;
            if ($urandom_range(0, 99) < 88)
                cell_idx = $urandom_range(0, grid_cells - 1);
            else
                cell_idx = $urandom_range(0, gufw_pkg::GRID_CELLS - 1);
            push_request(op, cell_idx, 2'($urandom_range(0, 3)));
        end
    endtask

    initial begin : rx_side
        int  stall_left;
        int  window;
        bit  calm;
        m_axis_tready = 1'b0;
        stall_left = 0;
        window = 0;
        calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                if (window == 0) begin
                    calm = ($urandom_range(0, 2) == 0);
                    window = $urandom_range(20, 80);
                end
                window--;
                if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("timeout with %0d results still pending", pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = gufw_pkg::CFG_REG_WIDTH;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        rx_hold_req = 1'b0;
        sent = 0;
        settings = 0;
        grid_cells = gufw_pkg::DIM_MAX * gufw_pkg::DIM_MAX;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, on the 64 x 64 grid left by reset
        push_request(OP_READ, 0, gufw_pkg::DIR_RIGHT);
        push_request(OP_READ_ALT, gufw_pkg::GRID_CELLS - 1, gufw_pkg::DIR_UP);
        push_request(gufw_pkg::OP_UNITE, 0, gufw_pkg::DIR_UP);
        push_request(gufw_pkg::OP_UNITE, 0, gufw_pkg::DIR_LEFT);
        push_request(gufw_pkg::OP_UNITE, 63, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_UNITE, gufw_pkg::GRID_CELLS - 1, gufw_pkg::DIR_DOWN);
        push_request(gufw_pkg::OP_FORCE, gufw_pkg::GRID_CELLS - 1, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_UNITE, 0, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_UNITE, 1, gufw_pkg::DIR_LEFT);
        push_request(gufw_pkg::OP_FORCE, 0, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_FORCE, 64, gufw_pkg::DIR_DOWN);
        push_request(gufw_pkg::OP_UNITE, 128, gufw_pkg::DIR_UP);
        push_request(gufw_pkg::OP_UNITE, 0, gufw_pkg::DIR_DOWN);
        push_request(gufw_pkg::OP_UNITE, 65, gufw_pkg::DIR_UP);
        push_request(gufw_pkg::OP_UNITE, 64, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_UNITE, gufw_pkg::GRID_CELLS - 2, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_UNITE, gufw_pkg::GRID_CELLS - 1, gufw_pkg::DIR_UP);
        push_request(OP_READ, 64, gufw_pkg::DIR_DOWN);

        // zero width and oversized height clamp to a single column of 64
        set_grid(7'd0, 7'd127);
        push_request(OP_READ, 64, gufw_pkg::DIR_LEFT);
        push_request(gufw_pkg::OP_UNITE, 5, gufw_pkg::DIR_LEFT);
        push_request(gufw_pkg::OP_FORCE, 63, gufw_pkg::DIR_DOWN);
        push_request(gufw_pkg::OP_UNITE, 0, gufw_pkg::DIR_DOWN);
        push_request(gufw_pkg::OP_UNITE, 10, gufw_pkg::DIR_DOWN);

        set_grid(7'd65, 7'd1);
        push_request(gufw_pkg::OP_UNITE, 63, gufw_pkg::DIR_RIGHT);
        push_request(gufw_pkg::OP_FORCE, 10, gufw_pkg::DIR_RIGHT);

        // random part over several grid shapes
        set_grid(7'd8, 7'd8);
        random_requests(120, 1'b1, 1'b0);
        set_grid(7'd0, 7'd0);
        random_requests(40, 1'b0, 1'b0);
        set_grid(7'd127, 7'd3);
        random_requests(100, 1'b0, 1'b0);
        set_grid(7'd5, 7'd7);
        random_requests(120, 1'b0, 1'b1);
        set_grid(7'd1, 7'd64);
        random_requests(80, 1'b0, 1'b0);
        set_grid(7'd64, 7'd1);
        random_requests(80, 1'b0, 1'b0);
        for (int k = 0; k < 2; k++) begin
            set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            random_requests(80, 1'b0, 1'b0);
        end
        set_grid(7'd64, 7'd64);
        random_requests(100, 1'b0, 1'b0);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("ran %0d requests over %0d grid shapes, including single cell and",
                 sent, settings + 1);
        $display("single row or column grids; %0d results compared field by field", checked);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
